/* rtl/sorted_timer_message_queue_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sorted timer message queue
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_TIMER_MESSAGE_QUEUE_CORE_MACROS_SVH
`define SORTED_TIMER_MESSAGE_QUEUE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STMQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/stmq_pkg.sv */
// ---------------------------------------------------------------------------
// Sorted timer message queue package
// Sizes, operation and status codes, and the buses between the controller
// and the row of slot cells.
// ---------------------------------------------------------------------------
package stmq_pkg;

    // Queue geometry and key width.
    localparam int SLOTS     = 32;
    localparam int TIME_BITS = 32;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int LINK_W    = $clog2(SLOTS) + 1;
    localparam int KEY_W     = TIME_BITS + 1;
    localparam int STEP_W    = $clog2(SLOTS + 1);

    // Field widths of the ports.
    localparam int OP_W       = 2;
    localparam int IN_SLOT_W  = 5;
    localparam int TIME_W     = 32;
    localparam int OUT_SLOT_W = 5;
    localparam int STATUS_W   = 2;

    // The empty link mark.
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 2'd0,
        OP_INSERT  = 2'd1,
        OP_DEQUEUE = 2'd2,
        OP_REMOVE  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_CONFLICT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_FIX,
        S_UNL_RD,
        S_UNL_FIX
    } t_state;

    // One write port into the cell row.
    typedef struct packed {
        logic              en_next;
        logic              en_prev;
        logic              q_set;
        logic              q_clr;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } t_wr_port;

    // Write command broadcast to every cell; the key goes with port a.
    typedef struct packed {
        t_wr_port         a;
        t_wr_port         b;
        logic             key_en;
        logic [KEY_W-1:0] key;
    } t_cell_cmd;

    // Read data handed along the cell row.
    typedef struct packed {
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
        logic [KEY_W-1:0]  key;
    } t_rd_bus;

endpackage

/* rtl/stmq_cell.sv */
// ---------------------------------------------------------------------------
// Slot cell
// Holds the links, sort key and membership bit of one slot, takes writes
// from the broadcast command and passes the read bus on to its neighbour.
// ---------------------------------------------------------------------------
module stmq_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [stmq_pkg::SLOT_W-1:0]     i_index,
    input  logic [stmq_pkg::SLOT_W-1:0]     i_rd_addr,
    input  stmq_pkg::t_cell_cmd             i_cmd,
    input  stmq_pkg::t_rd_bus               i_rd,
    output stmq_pkg::t_rd_bus               o_rd,
    output logic                            o_in_q
);

    logic [stmq_pkg::LINK_W-1:0] r_next;
    logic [stmq_pkg::LINK_W-1:0] r_prev;
    logic [stmq_pkg::KEY_W-1:0]  r_key;
    logic                        r_in_q;
    logic                        w_sel_a;
    logic                        w_sel_b;

    assign w_sel_a = (i_cmd.a.addr == i_index);
    assign w_sel_b = (i_cmd.b.addr == i_index);

    // Link and key storage; the controller never aims both ports at one field.
    always_ff @(posedge i_clk) begin
        priority if (w_sel_a && i_cmd.a.en_next) begin
            r_next <= i_cmd.a.next;
        end else if (w_sel_b && i_cmd.b.en_next) begin
            r_next <= i_cmd.b.next;
        end
        priority if (w_sel_a && i_cmd.a.en_prev) begin
            r_prev <= i_cmd.a.prev;
        end else if (w_sel_b && i_cmd.b.en_prev) begin
            r_prev <= i_cmd.b.prev;
        end
        if (w_sel_a && i_cmd.key_en) begin
            r_key <= i_cmd.key;
        end
    end

    // Membership bit, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_q <= 1'b0;
        end else if (w_sel_a && i_cmd.a.q_set) begin
            r_in_q <= 1'b1;
        end else if (w_sel_a && i_cmd.a.q_clr) begin
            r_in_q <= 1'b0;
        end
    end

    // Read chain: the addressed cell places its entry on the bus.
    always_comb begin
        if (i_rd_addr == i_index) begin
            o_rd.next = r_next;
            o_rd.prev = r_prev;
            o_rd.key  = r_key;
        end else begin
            o_rd = i_rd;
        end
    end

    assign o_in_q = r_in_q;

endmodule

/* rtl/stmq_ctrl.sv */
// ---------------------------------------------------------------------------
// Queue sequencer
// Holds head and tail, walks the list one entry a cycle for sorted insert
// and issues the link writes for append, insert and unlink.
// ---------------------------------------------------------------------------
module stmq_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [stmq_pkg::OP_W-1:0]           i_operation,
    input  logic [stmq_pkg::IN_SLOT_W-1:0]      i_slot,
    input  logic [stmq_pkg::TIME_W-1:0]         i_delay,
    input  logic [stmq_pkg::TIME_W-1:0]         i_start_time,
    input  logic [stmq_pkg::SLOTS-1:0]          i_in_q,
    input  stmq_pkg::t_rd_bus                   i_rd,
    output logic [stmq_pkg::SLOT_W-1:0]         o_rd_addr,
    output stmq_pkg::t_cell_cmd                 o_cmd,
    output logic                                o_strobe,
    output logic [stmq_pkg::OUT_SLOT_W-1:0]     o_out_slot,
    output logic                                o_out_valid,
    output logic [stmq_pkg::STATUS_W-1:0]       o_status
);

    stmq_pkg::t_state            r_state,  n_state;
    stmq_pkg::t_op               r_op,     n_op;
    logic [stmq_pkg::SLOT_W-1:0] r_s,      n_s;
    logic [stmq_pkg::KEY_W-1:0]  r_key,    n_key;
    logic [stmq_pkg::LINK_W-1:0] r_head,   n_head;
    logic [stmq_pkg::LINK_W-1:0] r_tail,   n_tail;
    logic [stmq_pkg::LINK_W-1:0] r_it,     n_it;
    logic [stmq_pkg::LINK_W-1:0] r_pv,     n_pv;
    logic [stmq_pkg::LINK_W-1:0] r_nx,     n_nx;
    logic [stmq_pkg::STEP_W-1:0] r_steps,  n_steps;
    logic                        r_strobe, n_strobe;
    logic [stmq_pkg::OUT_SLOT_W-1:0] r_out_slot, n_out_slot;
    logic                        r_out_valid, n_out_valid;
    stmq_pkg::t_status           r_status, n_status;

    logic [stmq_pkg::SLOT_W-1:0] w_slot_idx;
    logic                        w_slot_ok;
    logic [stmq_pkg::KEY_W-1:0]  w_key_in;

    function automatic logic link_ok(input logic [stmq_pkg::LINK_W-1:0] v);
        return v < stmq_pkg::NIL;
    endfunction

    // Writes that put slot s behind the present tail.
    function automatic stmq_pkg::t_cell_cmd link_tail(
        input logic [stmq_pkg::SLOT_W-1:0] s,
        input logic [stmq_pkg::LINK_W-1:0] tail
    );
        stmq_pkg::t_cell_cmd c;
        c           = '0;
        c.a.addr    = s;
        c.a.en_next = 1'b1;
        c.a.next    = stmq_pkg::NIL;
        c.a.en_prev = 1'b1;
        c.a.q_set   = 1'b1;
        if (link_ok(tail)) begin
            c.a.prev    = tail;
            c.b.en_next = 1'b1;
            c.b.addr    = tail[stmq_pkg::SLOT_W-1:0];
            c.b.next    = stmq_pkg::LINK_W'(s);
        end else begin
            c.a.prev    = stmq_pkg::NIL;
        end
        return c;
    endfunction

    assign w_slot_idx = stmq_pkg::SLOT_W'(i_slot);
    assign w_slot_ok  = (32'(i_slot) < 32'(stmq_pkg::SLOTS));
    assign w_key_in   = stmq_pkg::KEY_W'(stmq_pkg::TIME_BITS'(i_delay))
                      + stmq_pkg::KEY_W'(stmq_pkg::TIME_BITS'(i_start_time));

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= stmq_pkg::S_IDLE;
            r_head   <= stmq_pkg::NIL;
            r_tail   <= stmq_pkg::NIL;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_strobe <= n_strobe;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_s         <= n_s;
        r_key       <= n_key;
        r_it        <= n_it;
        r_pv        <= n_pv;
        r_nx        <= n_nx;
        r_steps     <= n_steps;
        r_out_slot  <= n_out_slot;
        r_out_valid <= n_out_valid;
        r_status    <= n_status;
    end

    // Next state, cell writes and result.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_s         = r_s;
        n_key       = r_key;
        n_head      = r_head;
        n_tail      = r_tail;
        n_it        = r_it;
        n_pv        = r_pv;
        n_nx        = r_nx;
        n_steps     = r_steps;
        n_strobe    = 1'b0;
        n_out_slot  = '0;
        n_out_valid = 1'b0;
        n_status    = stmq_pkg::ST_OK;
        o_cmd       = '0;
        o_rd_addr   = r_s;

        unique case (r_state)
            stmq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op  = stmq_pkg::t_op'(i_operation);
                    n_s   = w_slot_idx;
                    n_key = w_key_in;
                    if (stmq_pkg::t_op'(i_operation) == stmq_pkg::OP_DEQUEUE) begin
                        if (!link_ok(r_head)) begin
                            n_strobe = 1'b1;
                            n_status = stmq_pkg::ST_EMPTY;
                        end else begin
                            n_s     = r_head[stmq_pkg::SLOT_W-1:0];
                            n_state = stmq_pkg::S_UNL_RD;
                        end
                    end else if (!w_slot_ok) begin
                        n_strobe = 1'b1;
                        n_status = stmq_pkg::ST_CONFLICT;
                    end else if (stmq_pkg::t_op'(i_operation) == stmq_pkg::OP_REMOVE) begin
                        if (!i_in_q[w_slot_idx]) begin
                            n_strobe = 1'b1;
                            n_status = stmq_pkg::ST_CONFLICT;
                        end else begin
                            n_state = stmq_pkg::S_UNL_RD;
                        end
                    end else if (i_in_q[w_slot_idx]) begin
                        n_strobe = 1'b1;
                        n_status = stmq_pkg::ST_CONFLICT;
                    end else if (stmq_pkg::t_op'(i_operation) == stmq_pkg::OP_APPEND) begin
                        // Append completes in the accepting cycle.
                        o_cmd        = link_tail(w_slot_idx, r_tail);
                        o_cmd.key_en = 1'b1;
                        o_cmd.key    = w_key_in;
                        if (!link_ok(r_tail)) begin
                            n_head = stmq_pkg::LINK_W'(w_slot_idx);
                        end
                        n_tail   = stmq_pkg::LINK_W'(w_slot_idx);
                        n_strobe = 1'b1;
                    end else begin
                        // Sorted insert: store the key, then walk from the head.
                        o_cmd.a.addr = w_slot_idx;
                        o_cmd.key_en = 1'b1;
                        o_cmd.key    = w_key_in;
                        n_it         = r_head;
                        n_steps      = '0;
                        n_state      = stmq_pkg::S_WALK;
                    end
                end
            end

            stmq_pkg::S_WALK: begin
                o_rd_addr = r_it[stmq_pkg::SLOT_W-1:0];
                if (!link_ok(r_it) || r_steps == stmq_pkg::STEP_W'(stmq_pkg::SLOTS)) begin
                    o_cmd = link_tail(r_s, r_tail);
                    if (!link_ok(r_tail)) begin
                        n_head = stmq_pkg::LINK_W'(r_s);
                    end
                    n_tail   = stmq_pkg::LINK_W'(r_s);
                    n_strobe = 1'b1;
                    n_state  = stmq_pkg::S_IDLE;
                end else if (r_key <= i_rd.key) begin
                    // Place the slot in front of the current entry.
                    o_cmd.a.addr    = r_s;
                    o_cmd.a.en_next = 1'b1;
                    o_cmd.a.next    = r_it;
                    o_cmd.a.en_prev = 1'b1;
                    o_cmd.a.prev    = i_rd.prev;
                    o_cmd.a.q_set   = 1'b1;
                    o_cmd.b.addr    = r_it[stmq_pkg::SLOT_W-1:0];
                    o_cmd.b.en_prev = 1'b1;
                    o_cmd.b.prev    = stmq_pkg::LINK_W'(r_s);
                    n_pv            = i_rd.prev;
                    n_state         = stmq_pkg::S_INS_FIX;
                end else begin
                    n_it    = i_rd.next;
                    n_steps = r_steps + 1'b1;
                end
            end

            stmq_pkg::S_INS_FIX: begin
                // Point the entry before the new slot, or the head, at it.
                if (link_ok(r_pv)) begin
                    o_cmd.a.addr    = r_pv[stmq_pkg::SLOT_W-1:0];
                    o_cmd.a.en_next = 1'b1;
                    o_cmd.a.next    = stmq_pkg::LINK_W'(r_s);
                end else begin
                    n_head = stmq_pkg::LINK_W'(r_s);
                end
                n_strobe = 1'b1;
                n_state  = stmq_pkg::S_IDLE;
            end

            stmq_pkg::S_UNL_RD: begin
                // Fetch the neighbours and detach the slot itself.
                o_rd_addr       = r_s;
                n_nx            = i_rd.next;
                n_pv            = i_rd.prev;
                o_cmd.a.addr    = r_s;
                o_cmd.a.en_next = 1'b1;
                o_cmd.a.next    = stmq_pkg::NIL;
                o_cmd.a.en_prev = 1'b1;
                o_cmd.a.prev    = stmq_pkg::NIL;
                o_cmd.a.q_clr   = 1'b1;
                n_state         = stmq_pkg::S_UNL_FIX;
            end

            stmq_pkg::S_UNL_FIX: begin
                // Join the neighbours across the removed slot.
                if (link_ok(r_pv)) begin
                    o_cmd.a.addr    = r_pv[stmq_pkg::SLOT_W-1:0];
                    o_cmd.a.en_next = 1'b1;
                    o_cmd.a.next    = r_nx;
                end else begin
                    n_head = r_nx;
                end
                if (link_ok(r_nx)) begin
                    o_cmd.b.addr    = r_nx[stmq_pkg::SLOT_W-1:0];
                    o_cmd.b.en_prev = 1'b1;
                    o_cmd.b.prev    = r_pv;
                end else begin
                    n_tail = r_pv;
                end
                n_strobe = 1'b1;
                if (r_op == stmq_pkg::OP_DEQUEUE) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = stmq_pkg::OUT_SLOT_W'(r_s);
                end
                n_state = stmq_pkg::S_IDLE;
            end

            default: begin
                n_state = stmq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != stmq_pkg::S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_out_slot  = r_out_slot;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

endmodule

/* rtl/sorted_timer_message_queue_core.sv */
// ---------------------------------------------------------------------------
// Sorted timer message queue core
// Doubly linked queue of message slots kept in a row of slot cells, with a
// sequencer for append, sorted insert, dequeue and remove.
// ---------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a rising edge where start is high and busy is
//   low; i_operation, i_slot, i_delay and i_start_time are sampled there.
//   Every command yields one result beat on o_out_slot, o_out_valid and
//   o_status, shown for exactly one cycle with o_result_strobe high. The
//   receiver cannot stall, so the result must be taken in that cycle.
// Sequencing:
//   Append and every rejected command give their result in the cycle after
//   the beat, and busy stays low. Dequeue and remove pass S_UNL_RD and
//   S_UNL_FIX before the result. A sorted insert walks the list from the
//   head, one entry a cycle through the cell read chain, and lands in front
//   of the first entry with a key not below its own, or behind all queued
//   entries; at most SLOTS-1 entries can be queued when an insert is taken.
//   The next beat is accepted in the cycle the result is shown.
// Reset:
//   Synchronous reset empties the queue and clears every membership bit;
//   links and keys need no clearing, as only queued slots are ever read.
// ---------------------------------------------------------------------------
`include "sorted_timer_message_queue_core_macros.svh"

module sorted_timer_message_queue_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [stmq_pkg::OP_W-1:0]           i_operation,
    input  logic [stmq_pkg::IN_SLOT_W-1:0]      i_slot,
    input  logic [stmq_pkg::TIME_W-1:0]         i_delay,
    input  logic [stmq_pkg::TIME_W-1:0]         i_start_time,
    output logic                                o_result_strobe,
    output logic [stmq_pkg::OUT_SLOT_W-1:0]     o_out_slot,
    output logic                                o_out_valid,
    output logic [stmq_pkg::STATUS_W-1:0]       o_status
);

    stmq_pkg::t_rd_bus           w_chain [stmq_pkg::SLOTS+1];
    logic [stmq_pkg::SLOTS-1:0]  w_in_q;
    logic [stmq_pkg::SLOT_W-1:0] w_rd_addr;
    stmq_pkg::t_cell_cmd         w_cmd;
    logic                        w_ok_result;

    assign w_chain[0] = '0;

    // Row of slot cells; the read bus runs from cell 0 to the last cell.
    for (genvar g = 0; g < stmq_pkg::SLOTS; g++) begin : g_cell
        stmq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_index   (stmq_pkg::SLOT_W'(g)),
            .i_rd_addr (w_rd_addr),
            .i_cmd     (w_cmd),
            .i_rd      (w_chain[g]),
            .o_rd      (w_chain[g+1]),
            .o_in_q    (w_in_q[g])
        );
    end

    // Sequencer.
    stmq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_operation  (i_operation),
        .i_slot       (i_slot),
        .i_delay      (i_delay),
        .i_start_time (i_start_time),
        .i_in_q       (w_in_q),
        .i_rd         (w_chain[stmq_pkg::SLOTS]),
        .o_rd_addr    (w_rd_addr),
        .o_cmd        (w_cmd),
        .o_strobe     (o_result_strobe),
        .o_out_slot   (o_out_slot),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status)
    );

    // A result beat that reports success.
    assign w_ok_result = o_result_strobe && (o_status == stmq_pkg::ST_OK);

    // An accepted beat either occupies the block or is answered at once.
    `STMQ_ASSERT_NEXT(a_beat_handled, start && !busy, busy || o_result_strobe, "beat lost")
    // A result is shown only once the sequencer is free again.
    `STMQ_ASSERT_SAME(a_result_idle, o_result_strobe, !busy, "result while busy")
    // A returned slot comes only with a result beat and a good status.
    `STMQ_ASSERT_SAME(a_slot_ok, o_out_valid, w_ok_result, "bad slot result")
    // The block becomes busy only after taking a beat.
    `STMQ_ASSERT_SAME(a_busy_cause, $rose(busy), $past(start), "busy without beat")

endmodule
